>>> hdl/spbs_pkg.sv
// shared types and constants of the sorted prefix-sum budget search
package spbs_pkg;

   localparam int OP_W     = 2;
   localparam int VALUE_W  = 31;
   localparam int BUDGET_W = 32;
   localparam int FIT_W    = 11;

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic clear_count;
      logic ins_init;
      logic ins_read;
      logic ins_shift;
      logic ins_place;
      logic reb_init;
      logic reb_read;
      logic reb_write;
      logic q_init;
      logic q_read;
      logic q_step;
      logic q_done;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic full;
      logic pos_zero;
      logic shift_needed;
      logic reb_done;
      logic search_done;
   } sts_type;

endpackage

>>> hdl/spbs_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module spbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/spbs_datapath.sv
// datapath: sorted value store, prefix sum store, insert, rebuild and search registers
module spbs_datapath #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  spbs_pkg::cmd_type                 cmd,
   output spbs_pkg::sts_type                 sts,
   input  logic [spbs_pkg::VALUE_W-1:0]      req_item_value,
   input  logic signed [spbs_pkg::BUDGET_W-1:0] req_budget,
   output logic                              rsp_strobe,
   output logic [spbs_pkg::FIT_W-1:0]        rsp_fit_count
);
   import spbs_pkg::*;

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int SUM_W = VALUE_W + IDX_W;

   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic                rsp_strobe_ff;
   logic [FIT_W-1:0]    rsp_fit_count_ff;

   logic [CNT_W-1:0]    pos_m1;
   logic [CNT_W-1:0]    mid;
   logic [SUM_W-1:0]    acc_sum;
   logic                sum_fits;

   logic                val_wr_en, val_rd_en;
   logic [IDX_W-1:0]    val_wr_addr, val_rd_addr;
   logic [VALUE_W-1:0]  val_wr_data, val_rd_data;
   logic [SUM_W-1:0]    sum_rd_data;

   assign pos_m1   = pos_ff - CNT_W'(1);
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign acc_sum  = acc_ff + SUM_W'(val_rd_data);
   // budget is non-negative whenever a probe is compared
   assign sum_fits = sum_rd_data <= SUM_W'(budget_ff[BUDGET_W-2:0]);

   always_comb begin
      value_in  = cmd.capture ? req_item_value : value_ff;
      budget_in = cmd.capture ? req_budget : budget_ff;

      count_in = count_ff;
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.ins_place) begin
         count_in = count_ff + CNT_W'(1);
      end

      pos_in = pos_ff;
      if (cmd.ins_init) begin
         pos_in = count_ff;
      end else if (cmd.ins_shift) begin
         pos_in = pos_m1;
      end

      idx_in = idx_ff;
      acc_in = acc_ff;
      if (cmd.reb_init) begin
         idx_in = '0;
         acc_in = '0;
      end else if (cmd.reb_write) begin
         idx_in = idx_ff + CNT_W'(1);
         acc_in = acc_sum;
      end

      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.q_init) begin
         lo_in = '0;
         hi_in = budget_ff[BUDGET_W-1] ? '0 : count_ff;
      end else if (cmd.q_step) begin
         if (sum_fits) begin
            lo_in = mid + CNT_W'(1);
         end else begin
            hi_in = mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff         <= value_in;
      budget_ff        <= budget_in;
      pos_ff           <= pos_in;
      idx_ff           <= idx_in;
      acc_ff           <= acc_in;
      lo_ff            <= lo_in;
      hi_ff            <= hi_in;
      rsp_fit_count_ff <= FIT_W'(lo_ff);
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.q_done;
      end
   end

   assign val_wr_en   = cmd.ins_shift | cmd.ins_place;
   assign val_wr_addr = pos_ff[IDX_W-1:0];
   assign val_wr_data = cmd.ins_shift ? val_rd_data : value_ff;
   assign val_rd_en   = cmd.ins_read | cmd.reb_read;
   assign val_rd_addr = cmd.ins_read ? pos_m1[IDX_W-1:0] : idx_ff[IDX_W-1:0];

   spbs_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_values (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_en   (val_rd_en),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   spbs_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ELEMENTS)) u_sums (
      .clock   (clock),
      .wr_en   (cmd.reb_write),
      .wr_addr (idx_ff[IDX_W-1:0]),
      .wr_data (acc_sum),
      .rd_en   (cmd.q_read),
      .rd_addr (mid[IDX_W-1:0]),
      .rd_data (sum_rd_data)
   );

   assign sts.full         = count_ff == CNT_W'(MAX_ELEMENTS);
   assign sts.pos_zero     = pos_ff == '0;
   assign sts.shift_needed = val_rd_data > value_ff;
   assign sts.reb_done     = idx_ff == count_ff;
   assign sts.search_done  = lo_ff >= hi_ff;

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_fit_count = rsp_fit_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ELEMENTS)) else $error("loaded count above capacity");
   a_search_order: assert property (@(posedge clock) disable iff (reset)
      cmd.q_step |-> lo_ff < hi_ff) else $error("probe with empty search range");
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(cmd.q_done)) else $error("strobe without finished search");

endmodule

>>> hdl/spbs_ctrl.sv
// controller: sequences clear, sorted insert, prefix rebuild and binary search
module spbs_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [spbs_pkg::OP_W-1:0]   req_op,
   output logic                        busy,
   output spbs_pkg::cmd_type           cmd,
   input  spbs_pkg::sts_type           sts
);
   import spbs_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_INS_CHK = 3'd1;
   localparam logic [2:0] ST_INS_CMP = 3'd2;
   localparam logic [2:0] ST_REB_CHK = 3'd3;
   localparam logic [2:0] ST_REB_ADD = 3'd4;
   localparam logic [2:0] ST_Q_INIT  = 3'd5;
   localparam logic [2:0] ST_Q_CHK   = 3'd6;
   localparam logic [2:0] ST_Q_CMP   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       sums_valid_ff, sums_valid_in;

   always_comb begin
      state_in      = state_ff;
      sums_valid_in = sums_valid_ff;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (req_op)
                  OP_CLEAR: begin
                     cmd.clear_count = 1'b1;
                     sums_valid_in   = 1'b0;
                  end
                  OP_LOAD: begin
                     if (!sts.full) begin
                        cmd.ins_init = 1'b1;
                        state_in     = ST_INS_CHK;
                     end
                  end
                  OP_QUERY: begin
                     if (sums_valid_ff) begin
                        state_in = ST_Q_INIT;
                     end else begin
                        cmd.reb_init = 1'b1;
                        state_in     = ST_REB_CHK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_INS_CHK: begin
            if (sts.pos_zero) begin
               cmd.ins_place = 1'b1;
               sums_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               cmd.ins_read = 1'b1;
               state_in     = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (sts.shift_needed) begin
               cmd.ins_shift = 1'b1;
               state_in      = ST_INS_CHK;
            end else begin
               cmd.ins_place = 1'b1;
               sums_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_REB_CHK: begin
            if (sts.reb_done) begin
               sums_valid_in = 1'b1;
               state_in      = ST_Q_INIT;
            end else begin
               cmd.reb_read = 1'b1;
               state_in     = ST_REB_ADD;
            end
         end
         ST_REB_ADD: begin
            cmd.reb_write = 1'b1;
            state_in      = ST_REB_CHK;
         end
         ST_Q_INIT: begin
            cmd.q_init = 1'b1;
            state_in   = ST_Q_CHK;
         end
         ST_Q_CHK: begin
            if (sts.search_done) begin
               cmd.q_done = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.q_read = 1'b1;
               state_in   = ST_Q_CMP;
            end
         end
         ST_Q_CMP: begin
            cmd.q_step = 1'b1;
            state_in   = ST_Q_CHK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sums_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sums_valid_ff <= sums_valid_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

   a_place_room: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_place |-> !sts.full) else $error("insert into full store");
   a_rebuild_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.reb_write |-> !sts.reb_done) else $error("rebuild past loaded count");
   a_done_range: assert property (@(posedge clock) disable iff (reset)
      cmd.q_done |-> sts.search_done) else $error("search finished early");
   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !busy) else $error("busy right after reset");

endmodule

>>> hdl/sorted_prefix_sum_budget_search.sv
// top level of the sorted prefix-sum budget search
// Usage: drive req_op, req_item_value and req_budget with start high; the
// transaction is taken on a clock edge where start is high and busy is low.
// op clear empties the store, op load inserts a value in sorted
// order, op query returns how many of the smallest values fit the budget.
// Only a query gives a result: rsp_strobe is high for one cycle with
// rsp_fit_count; the receiver cannot stall, so it must take it then.
// A load reads and compares the stored values from the back of the value
// ram, shifting each one larger than the new value up one place, then
// writes the new value into the gap. A query runs a binary search over the
// loaded values, probing the sum ram once per step; the first query after
// loads first rebuilds the prefix sums. A load into a full store is dropped.
// Reset empties the store; ram contents are left as they are and are only
// read below the loaded count.
module sorted_prefix_sum_budget_search #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [spbs_pkg::OP_W-1:0]            req_op,
   input  logic [spbs_pkg::VALUE_W-1:0]         req_item_value,
   input  logic signed [spbs_pkg::BUDGET_W-1:0] req_budget,
   output logic                                 rsp_strobe,
   output logic [spbs_pkg::FIT_W-1:0]           rsp_fit_count
);
   import spbs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   spbs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .busy   (busy),
      .cmd    (cmd),
      .sts    (sts)
   );

   spbs_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_item_value (req_item_value),
      .req_budget     (req_budget),
      .rsp_strobe     (rsp_strobe),
      .rsp_fit_count  (rsp_fit_count)
   );

endmodule
